@@ design/arfd_pkg.sv @@
// shared types and constants for the audio ring fifo frame drain unit
package arfd_pkg;

  localparam int DEF_MAX_DEPTH_LOG2 = 14;
  localparam int DEF_MAX_CHANNELS   = 8;

  localparam int SAMPLE_W    = 32;
  localparam int CHAN_IDX_W  = 3;
  localparam int FILL_W      = 15;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

  localparam logic [CFG_DATA_W-1:0] RST_CHANNEL_COUNT = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_CAPACITY_LOG2 = 4'd14;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_CAPACITY_LOG2 = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample_out;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic                  underrun;
    logic [FILL_W-1:0]     fill_level;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] channel_count;
    logic [CFG_DATA_W-1:0] capacity_log2;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

endpackage

@@ design/arfd_front.sv @@
// input stage: accepts transactions and classifies them into commands
module arfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arfd_pkg::in_t  in_data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output arfd_pkg::cmd_t cmd_o
);

  logic           valid_q, valid_d;
  arfd_pkg::cmd_t cmd_q, cmd_d;
  logic           take;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (take) begin
      valid_d      = 1'b1;
      cmd_d.kind   = (in_data_i.opcode == arfd_pkg::OP_PULL) ? arfd_pkg::CMD_PULL
                                                             : arfd_pkg::CMD_PUSH;
      cmd_d.sample = in_data_i.sample_in;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

@@ design/arfd_cmd_queue.sv @@
// short command queue between the front and back stages
module arfd_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  arfd_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output arfd_pkg::cmd_t pop_cmd_o
);

  localparam int AW = arfd_pkg::CMDQ_AW;

  arfd_pkg::cmd_t     slots_q [arfd_pkg::CMDQ_DEPTH];
  logic [AW-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]        count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != (AW+1)'(arfd_pkg::CMDQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slots_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = do_push ? wptr_q + AW'(1) : wptr_q;
    rptr_d  = do_pop  ? rptr_q + AW'(1) : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/arfd_back.sv @@
// execution stage: sample store, ring counters and frame sequencer
module arfd_back #(
  parameter int MAX_DEPTH_LOG2 = arfd_pkg::DEF_MAX_DEPTH_LOG2,
  parameter int MAX_CHANNELS   = arfd_pkg::DEF_MAX_CHANNELS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  arfd_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  arfd_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arfd_pkg::out_t out_data_o
);

  localparam int AW    = MAX_DEPTH_LOG2;
  localparam int CNT_W = MAX_DEPTH_LOG2 + 1;
  localparam int DEPTH = 1 << MAX_DEPTH_LOG2;
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int KW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LW    = $clog2(MAX_DEPTH_LOG2 + 1);

  logic [arfd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [arfd_pkg::SAMPLE_W-1:0] rd_q;

  arfd_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0] wc_q, wc_d, rc_q, rc_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             under_q, under_d;
  logic [KW-1:0]    k_q, k_d, klast_q, klast_d;

  logic             s2_valid_q, s2_valid_d;
  logic             s2_under_q;
  logic [KW-1:0]    s2_k_q;
  logic             s2_last_q;
  logic [CNT_W-1:0] s2_fill_q;

  logic [CW-1:0]    ch_eff;
  logic [LW-1:0]    lg_eff;
  logic [CNT_W-1:0] cap;
  logic [AW-1:0]    mask;
  logic [CNT_W-1:0] fill_now;
  logic             full;
  logic             under_now;
  logic             is_pull, is_push;
  logic             wr_en, rd_en, issue, start_pull;

  always_comb begin
    if (cfg_i.channel_count == '0) begin
      ch_eff = CW'(1);
    end else if (32'(cfg_i.channel_count) > 32'(MAX_CHANNELS)) begin
      ch_eff = CW'(MAX_CHANNELS);
    end else begin
      ch_eff = CW'(cfg_i.channel_count);
    end
    if (cfg_i.capacity_log2 == '0) begin
      lg_eff = LW'(1);
    end else if (32'(cfg_i.capacity_log2) > 32'(MAX_DEPTH_LOG2)) begin
      lg_eff = LW'(MAX_DEPTH_LOG2);
    end else begin
      lg_eff = LW'(cfg_i.capacity_log2);
    end
  end

  assign cap       = CNT_W'(1) << lg_eff;
  assign mask      = AW'(cap - CNT_W'(1));
  assign fill_now  = wc_q - rc_q;
  assign full      = (fill_now >= cap);
  assign under_now = (32'(fill_now) < 32'(ch_eff));
  assign is_pull   = cmd_valid_i && (cmd_i.kind == arfd_pkg::CMD_PULL);
  assign is_push   = cmd_valid_i && (cmd_i.kind == arfd_pkg::CMD_PUSH);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arfd_pkg::ST_IDLE: begin
        if (is_pull) begin
          state_d = arfd_pkg::ST_EMIT;
        end
      end
      arfd_pkg::ST_EMIT: begin
        if (issue && (k_q == klast_q)) begin
          state_d = arfd_pkg::ST_IDLE;
        end
      end
      default: state_d = arfd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    start_pull  = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      arfd_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        wr_en       = is_push && !full;
        start_pull  = is_pull;
      end
      arfd_pkg::ST_EMIT: begin
        issue = !s2_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign rd_en = issue && !under_q;

  always_comb begin
    wc_d       = wr_en ? wc_q + CNT_W'(1) : wc_q;
    rc_d       = rd_en ? rc_q + CNT_W'(1) : rc_q;
    k_d        = k_q;
    klast_d    = klast_q;
    fill_d     = fill_q;
    under_d    = under_q;
    s2_valid_d = s2_valid_q;
    if (start_pull) begin
      k_d     = '0;
      klast_d = KW'(ch_eff - CW'(1));
      under_d = under_now;
      fill_d  = under_now ? fill_now : fill_now - CNT_W'(ch_eff);
    end else if (issue) begin
      k_d = k_q + KW'(1);
    end
    if (issue) begin
      s2_valid_d = 1'b1;
    end else if (out_ready_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= arfd_pkg::ST_IDLE;
      wc_q       <= '0;
      rc_q       <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wc_q       <= wc_d;
      rc_q       <= rc_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    klast_q <= klast_d;
    fill_q  <= fill_d;
    under_q <= under_d;
    if (issue) begin
      s2_under_q <= under_q;
      s2_k_q     <= k_q;
      s2_last_q  <= (k_q == klast_q);
      s2_fill_q  <= fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wc_q[AW-1:0] & mask] <= cmd_i.sample;
    end
    if (rd_en) begin
      rd_q <= mem[rc_q[AW-1:0] & mask];
    end
  end

  assign out_valid_o              = s2_valid_q;
  assign out_data_o.sample_out    = s2_under_q ? '0 : rd_q;
  assign out_data_o.channel_index = arfd_pkg::CHAN_IDX_W'(s2_k_q);
  assign out_data_o.underrun      = s2_under_q;
  assign out_data_o.fill_level    = arfd_pkg::FILL_W'(s2_fill_q);
  assign out_data_o.last          = s2_last_q;

endmodule

@@ design/audio_ring_fifo_frame_drain_unit.sv @@
// top level of the audio ring fifo frame drain unit
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i/in_ready_o  | in_data_i: opcode, sample_in
//  out     | out_valid_o/out_ready_i| out_data_o: sample_out .. last
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// a push is handled in the idle state of the sequencer; a pull starts there and then emits
// one result per channel in turn, through the single read port of the sample store
// results leave from a registered stage behind the store read data
// reset clears the counters, queue and valid flags; the store is not cleared
// the input side keeps taking transactions into the queue while output stalls, until the queue is full
module audio_ring_fifo_frame_drain_unit #(
  parameter int MAX_DEPTH_LOG2 = arfd_pkg::DEF_MAX_DEPTH_LOG2,
  parameter int MAX_CHANNELS   = arfd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  arfd_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output arfd_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [arfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [arfd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  arfd_pkg::cfg_t cfg_q, cfg_d;
  logic           f_valid, f_ready, q_valid, q_ready;
  arfd_pkg::cmd_t f_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (arfd_pkg::cfg_idx_e'(cfg_index_i))
        arfd_pkg::CFG_CHANNEL_COUNT: cfg_d.channel_count = cfg_data_i;
        arfd_pkg::CFG_CAPACITY_LOG2: cfg_d.capacity_log2 = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= arfd_pkg::RST_CHANNEL_COUNT;
      cfg_q.capacity_log2 <= arfd_pkg::RST_CAPACITY_LOG2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  arfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  arfd_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  arfd_back #(
    .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2),
    .MAX_CHANNELS   (MAX_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ design/arfd_checker.sv @@
// port-level assertions for the audio ring fifo frame drain unit
module arfd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input arfd_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_under_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.underrun |-> out_data_o.sample_out == '0)
    else $error("underrun result carries a nonzero sample");

  a_frame_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a frame");

  a_frame_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      (out_data_o.channel_index ==
         arfd_pkg::CHAN_IDX_W'($past(out_data_o.channel_index) + 3'd1)) &&
      (out_data_o.fill_level == $past(out_data_o.fill_level)) &&
      (out_data_o.underrun == $past(out_data_o.underrun)))
    else $error("frame results out of sequence");

endmodule

bind audio_ring_fifo_frame_drain_unit arfd_checker u_arfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ test/tb_top.sv @@
// testbench for the audio ring fifo frame drain unit: directed table, then random phases
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arfd_pkg::*;

  localparam int DEPTH       = 1 << DEF_MAX_DEPTH_LOG2;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT       = 2000;
  localparam int N_PHASES    = 8;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic                known;
    logic [SAMPLE_W-1:0] s0;
    logic [SAMPLE_W-1:0] s1;
    logic                under;
    logic [FILL_W-1:0]   fill;
  } dir_row_t;

  // default config: two channels, full capacity
  localparam dir_row_t DIR_ROWS [15] = '{
    '{OP_PULL, 32'hDEADBEEF, 1'b1, 32'h0, 32'h0, 1'b1, 15'd0},
    '{OP_PUSH, 32'h00000000, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PULL, 32'h00000000, 1'b1, 32'h0, 32'h0, 1'b1, 15'd1},
    '{OP_PUSH, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PULL, 32'hFFFFFFFF, 1'b1, 32'h0, 32'hFFFFFFFF, 1'b0, 15'd0},
    '{OP_PUSH, 32'h80000001, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PUSH, 32'h7FFFFFFE, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PUSH, 32'hA5A5A5A5, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PULL, 32'h12345678, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PULL, 32'h00000000, 1'b1, 32'h0, 32'h0, 1'b1, 15'd1},
    '{OP_PUSH, 32'h5A5A5A5A, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PULL, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PUSH, 32'h00000001, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PUSH, 32'hFFFFFFFE, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0},
    '{OP_PUSH, 32'h0F0F0F0F, 1'b0, 32'h0, 32'h0, 1'b0, 15'd0}
  };

  localparam logic [CFG_DATA_W-1:0] PH_CH  [N_PHASES] = '{1, 8, 3, 0, 15, 9, 5, 2};
  localparam logic [CFG_DATA_W-1:0] PH_CAP [N_PHASES] = '{1, 2, 14, 3, 15, 0, 4, 6};
  localparam int                    PH_N   [N_PHASES] = '{30, 30, 40, 25, 30, 25, 30, 50};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // shadow copy of the fifo
  logic [SAMPLE_W-1:0]   shadow_mem [DEPTH];
  bit                    shadow_set [DEPTH];
  logic [FILL_W-1:0]     wr_cnt = '0;
  logic [FILL_W-1:0]     rd_cnt = '0;
  logic [CFG_DATA_W-1:0] ch_reg  = RST_CHANNEL_COUNT;
  logic [CFG_DATA_W-1:0] cap_reg = RST_CAPACITY_LOG2;

  out_t due_words [$];
  int   miss_count  = 0;
  int   idle_cycles = 0;
  bit   hold_req    = 1'b0;
  bit   quiet       = 1'b0;

  audio_ring_fifo_frame_drain_unit uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned frame_width();
    if (ch_reg == 0) return 1;
    if (ch_reg > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
    return ch_reg;
  endfunction

  function automatic int unsigned cap_words_of(logic [CFG_DATA_W-1:0] l);
    if (l == 0) return 2;
    if (l > DEF_MAX_DEPTH_LOG2) return 1 << DEF_MAX_DEPTH_LOG2;
    return 1 << l;
  endfunction

  function automatic logic [FILL_W-1:0] fill_now();
    return wr_cnt - rd_cnt;
  endfunction

  // pops after a capacity switch must only land on entries already written
  function automatic bit cap_switch_clean(logic [CFG_DATA_W-1:0] next_log2);
    int unsigned m;
    int unsigned fill;
    m = cap_words_of(next_log2) - 1;
    fill = fill_now();
    for (int unsigned i = 0; i < fill; i++)
      if (!shadow_set[(rd_cnt + i) & m]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fifo_apply(input in_t d, input bit keep);
    int unsigned cap;
    int unsigned ch;
    int unsigned idx;
    logic [FILL_W-1:0] fill;
    bit dry;
    out_t w;
    cap = cap_words_of(cap_reg);
    ch = frame_width();
    fill = fill_now();
    if (d.opcode == OP_PUSH) begin
      if (fill < cap) begin
        idx = wr_cnt & (cap - 1);
        shadow_mem[idx] = d.sample_in;
        shadow_set[idx] = 1'b1;
        wr_cnt = wr_cnt + 1'b1;
      end
      return;
    end
    dry = fill < ch;
    if (!dry) fill = fill - ch;
    for (int unsigned k = 0; k < ch; k++) begin
      w.sample_out = '0;
      if (!dry) begin
        w.sample_out = shadow_mem[rd_cnt & (cap - 1)];
        rd_cnt = rd_cnt + 1'b1;
      end
      w.channel_index = k[CHAN_IDX_W-1:0];
      w.underrun      = dry;
      w.fill_level    = fill;
      w.last          = (k == ch - 1);
      if (keep) due_words.push_back(w);
    end
  endtask

  task automatic send_item(input in_t d, input bit keep);
    int unsigned n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    fifo_apply(d, keep);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CHANNEL_COUNT) ch_reg = val;
    else cap_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic log_miss(input string why, input out_t want, input out_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("%s: want %08h ch %0d ur %0b fill %0d last %0b", why, want.sample_out,
               want.channel_index, want.underrun, want.fill_level, want.last,
               "  got %08h ch %0d ur %0b fill %0d last %0b", got.sample_out,
               got.channel_index, got.underrun, got.fill_level, got.last);
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_words.size() == 0) begin
        log_miss("unexpected result", '0, out_data_o);
      end else begin
        want = due_words.pop_front();
        if (out_data_o.sample_out !== want.sample_out ||
            out_data_o.channel_index !== want.channel_index ||
            out_data_o.underrun !== want.underrun ||
            out_data_o.fill_level !== want.fill_level ||
            out_data_o.last !== want.last)
          log_miss("result mismatch", want, out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : sink
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        n = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 9);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  initial begin : stim
    in_t d;
    out_t w;
    int unsigned n;
    foreach (shadow_set[i]) shadow_set[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[r]) begin
      d.opcode    = DIR_ROWS[r].op;
      d.sample_in = DIR_ROWS[r].sample;
      send_item(d, !DIR_ROWS[r].known);
      if (DIR_ROWS[r].known) begin
        for (int k = 0; k < 2; k++) begin
          w.sample_out    = (k == 0) ? DIR_ROWS[r].s0 : DIR_ROWS[r].s1;
          w.channel_index = k[CHAN_IDX_W-1:0];
          w.underrun      = DIR_ROWS[r].under;
          w.fill_level    = DIR_ROWS[r].fill;
          w.last          = (k == 1);
          due_words.push_back(w);
        end
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      // drain one sample per frame when the new mask would expose unwritten entries
      if (!cap_switch_clean(PH_CAP[p])) begin
        write_reg(CFG_CHANNEL_COUNT, 4'd1);
        n = fill_now();
        d.opcode = OP_PULL;
        repeat (n) begin
          d.sample_in = $urandom();
          send_item(d, 1'b1);
        end
        wait_idle();
      end
      write_reg(CFG_CAPACITY_LOG2, PH_CAP[p]);
      write_reg(CFG_CHANNEL_COUNT, PH_CH[p]);
      if (p == 2) hold_req = 1'b1;
      quiet = (p == N_PHASES - 1);
      for (int i = 0; i < PH_N[p]; i++) begin
        d.opcode    = ($urandom_range(0, frame_width()) == 0) ? OP_PULL : OP_PUSH;
        d.sample_in = $urandom();
        send_item(d, 1'b1);
      end
    end

    wait_idle();
    if (miss_count == 0 && due_words.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
